// ===== rtl/core/makd_pkg.sv =====
// shared types and constants for the morse audio keying detector
// no dependencies; imported by morse_audio_keying_detector
package makd_pkg;

	// configuration register widths
	localparam int LEVEL_W    = 7;
	localparam int DEBOUNCE_W = 10;
	localparam int LEN_W      = 20;

	// register map, word index into the apb space
	typedef enum logic [2:0] {
		REG_LEVEL_THRESHOLD = 3'd0,
		REG_DEBOUNCE_LEN    = 3'd1,
		REG_DASH_MIN_LEN    = 3'd2,
		REG_LETTER_GAP_LEN  = 3'd3,
		REG_WORD_GAP_LEN    = 3'd4
	} reg_idx_t;

	// output symbol codes
	typedef enum logic [1:0] {
		SYM_DOT        = 2'd0,
		SYM_DASH       = 2'd1,
		SYM_LETTER_GAP = 2'd2,
		SYM_WORD_GAP   = 2'd3
	} sym_t;

	// register reset values
	localparam logic [LEVEL_W-1:0]    LEVEL_RST      = 7'd1;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 10'd44;
	localparam logic [LEN_W-1:0]      DASH_MIN_RST   = 20'd8820;
	localparam logic [LEN_W-1:0]      LETTER_GAP_RST = 20'd17199;
	localparam logic [LEN_W-1:0]      WORD_GAP_RST   = 20'd34839;

endpackage

// ===== rtl/core/morse_audio_keying_detector.sv =====
// morse keying detector: tone detect, debounce, run timing, symbol output
// depends on makd_pkg
//
// The block takes one signed audio sample per beat and can accept a new sample
// every clock cycle; a sample is held in the input register and its symbol
// (dot, dash, letter gap or word gap), if any, moves to the result register
// once that register is free. Throughput drops only while the result
// register holds a symbol that the consumer has not taken.
// A sample is tone when its magnitude is strictly above level_threshold; a
// keying change is confirmed after debounce_len consecutive disagreeing
// samples. The run counter of COUNT_WIDTH bits saturates at all ones.
// Registers sit on an apb-style port at byte addresses 0, 4, 8, 12 and 16 and
// must only be written while no sample is in flight.
module morse_audio_keying_detector
	import makd_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 8,
	parameter int COUNT_WIDTH  = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// sample channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	// symbol channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              symbol
);

	localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
	localparam logic [COUNT_WIDTH-1:0] RUN_MAX = {COUNT_WIDTH{1'b1}};

	// configuration registers
	logic [LEVEL_W-1:0]    level_q;
	logic [DEBOUNCE_W-1:0] debounce_len_q;
	logic [LEN_W-1:0]      dash_min_q;
	logic [LEN_W-1:0]      letter_gap_q;
	logic [LEN_W-1:0]      word_gap_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;

	// pipeline and detector state
	logic                          valid_s1;
	logic [SAMPLE_WIDTH-1:0]       sample_s1;
	logic                          tone_q;
	logic [DEBOUNCE_W-1:0]         debounce_q;
	logic [COUNT_WIDTH-1:0]        run_q;
	logic                          gap_armed_q;
	logic                          out_valid_q;
	sym_t                          symbol_q;

	// combinational step results
	logic                    advance;
	logic                    step;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic                    is_tone;
	logic [COUNT_WIDTH-1:0]  run_inc;
	logic [CMP_W-1:0]        run_cmp;
	logic [DEBOUNCE_W-1:0]   debounce_inc;
	logic                    disagree;
	logic                    confirm;
	logic                    emit;
	sym_t                    sym_next;

	// apb write decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q        <= LEVEL_RST;
			debounce_len_q <= DEBOUNCE_RST;
			dash_min_q     <= DASH_MIN_RST;
			letter_gap_q   <= LETTER_GAP_RST;
			word_gap_q     <= WORD_GAP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LEVEL_THRESHOLD: level_q        <= pwdata[LEVEL_W-1:0];
				REG_DEBOUNCE_LEN:    debounce_len_q <= pwdata[DEBOUNCE_W-1:0];
				REG_DASH_MIN_LEN:    dash_min_q     <= pwdata[LEN_W-1:0];
				REG_LETTER_GAP_LEN:  letter_gap_q   <= pwdata[LEN_W-1:0];
				REG_WORD_GAP_LEN:    word_gap_q     <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// apb read mux
	always_comb begin
		case (cfg_idx)
			REG_LEVEL_THRESHOLD: prdata = 32'(level_q);
			REG_DEBOUNCE_LEN:    prdata = 32'(debounce_len_q);
			REG_DASH_MIN_LEN:    prdata = 32'(dash_min_q);
			REG_LETTER_GAP_LEN:  prdata = 32'(letter_gap_q);
			REG_WORD_GAP_LEN:    prdata = 32'(word_gap_q);
			default:             prdata = 32'd0;
		endcase
	end

	// handshake: result stage frees when empty or taken
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
		end
	end

	// tone detect, magnitude of the most negative sample taken without wrap
	assign mag     = sample_s1[SAMPLE_WIDTH-1] ? (~sample_s1 + 1'b1) : sample_s1;
	assign is_tone = mag > SAMPLE_WIDTH'(level_q);

	// saturating run count and debounce
	assign run_inc      = (run_q == RUN_MAX) ? run_q : (run_q + 1'b1);
	assign run_cmp      = CMP_W'(run_inc);
	assign debounce_inc = debounce_q + 1'b1;
	assign disagree     = is_tone != tone_q;
	assign confirm      = disagree && !(debounce_inc < debounce_len_q);

	// symbol decision on a confirmed transition
	always_comb begin
		emit     = 1'b0;
		sym_next = SYM_DOT;
		if (confirm) begin
			if (is_tone) begin
				if (gap_armed_q) begin
					if (run_cmp >= CMP_W'(word_gap_q)) begin
						emit     = 1'b1;
						sym_next = SYM_WORD_GAP;
					end else if (run_cmp >= CMP_W'(letter_gap_q)) begin
						emit     = 1'b1;
						sym_next = SYM_LETTER_GAP;
					end
				end
			end else begin
				emit     = 1'b1;
				sym_next = (run_cmp >= CMP_W'(dash_min_q)) ? SYM_DASH : SYM_DOT;
			end
		end
	end

	// detector state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q      <= 1'b0;
			debounce_q  <= '0;
			run_q       <= '0;
			gap_armed_q <= 1'b0;
		end else if (step) begin
			if (!disagree) begin
				debounce_q <= '0;
				run_q      <= run_inc;
			end else if (!confirm) begin
				debounce_q <= debounce_inc;
				run_q      <= run_inc;
			end else begin
				debounce_q  <= '0;
				run_q       <= '0;
				tone_q      <= is_tone;
				gap_armed_q <= !is_tone;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			symbol_q <= sym_next;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;

	// a confirmed transition restarts the run and debounce counts
	a_confirm_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(step && confirm) |=> (run_q == '0) && (debounce_q == '0))
		else $error("counters not cleared after confirmed transition");

	// without a transition the run count never falls to zero
	a_run_grows : assert property (@(posedge clk) disable iff (!arst_n)
		(step && !confirm) |=> (run_q != '0))
		else $error("run count cleared without transition");

	// tone end always yields a dot or dash and arms the gap
	a_tone_end : assert property (@(posedge clk) disable iff (!arst_n)
		(step && confirm && !is_tone) |=> out_valid_q && gap_armed_q && !tone_q
			&& (symbol_q == SYM_DOT || symbol_q == SYM_DASH))
		else $error("tone end without dot or dash");

	// tone start disarms the gap and never yields a dot or dash
	a_tone_start : assert property (@(posedge clk) disable iff (!arst_n)
		(step && confirm && is_tone) |=> tone_q && !gap_armed_q
			&& (!out_valid_q || symbol_q == SYM_LETTER_GAP || symbol_q == SYM_WORD_GAP))
		else $error("bad symbol at tone start");

endmodule
